@@ hdl/tlv_pkg.sv @@
// Package for the TLV stream parser: status codes and the byte-wide CRC-32 step.
`default_nettype none

package tlv_pkg;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StTooMany  = 2'd1;
  localparam logic [1:0] StParse    = 2'd2;
  localparam logic [1:0] StMismatch = 2'd3;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  // Advance a zlib-style CRC-32 by one byte, with the usual inversions.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc;
    c[7:0] = c[7:0] ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return ~c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/tlv_stream_parser_crc32_core.sv @@
// Top level of the TLV stream parser with chained CRC-32 check.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   data_byte_i, last_byte_i
// out       output     out_valid_o / out_ready_i value_byte_o .. status_o
// cfg       input      cfg_we_i                  cfg_data_i (checksum type)
//
// One word per cycle while the result is drained: each accepted word updates
// the parser state and loads the result register at the same edge.
// The byte-wide CRC-32 step plus header compare sets the path length.
// A stalled result holds; a new word is taken whenever the result register
// is empty or is being drained in the same cycle.
// Reset clears the parser state, the result valid and the checksum type.

module tlv_stream_parser_crc32_core #(
  parameter int MAX_RECORDS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       value_byte_o,
  output logic             value_valid_o,
  output logic [4:0]       record_index_o,
  output logic [7:0]       record_type_o,
  output logic [15:0]      record_length_o,
  output logic             record_done_o,
  output logic             message_done_o,
  output logic [1:0]       status_o
);

  // Record counter holds 0 .. MAX_RECORDS.
  localparam int CntW = $clog2(MAX_RECORDS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_RECORDS);

  // Parser phases.
  localparam logic [2:0] PhType   = 3'd0;
  localparam logic [2:0] PhLenHi  = 3'd1;
  localparam logic [2:0] PhLenLo  = 3'd2;
  localparam logic [2:0] PhValue  = 3'd3;
  localparam logic [2:0] PhIgnore = 3'd4;

  logic [7:0]      chk_type_q;
  logic [2:0]      phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      type_q, type_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     left_q, left_d;
  logic [31:0]     crc_q, crc_d;
  logic [31:0]     crc_start_q, crc_start_d;
  logic            cmpf_q, cmpf_d;
  logic [1:0]      status_q, status_d;

  // Values after this word, before the end-of-message clear.
  logic [2:0]      nx_phase;
  logic [CntW-1:0] nx_count;
  logic [7:0]      nx_type;
  logic [15:0]     nx_len;
  logic [15:0]     nx_left;
  logic [31:0]     nx_crc;
  logic [31:0]     nx_crc_start;
  logic            nx_cmpf;
  logic [1:0]      nx_status;

  logic            vvalid, rdone, fin;
  logic [31:0]     crc_step;
  logic [15:0]     pos, left_dec;
  logic [7:0]      exp_byte;
  logic            byte_miss;
  logic [CntW+4:0] idx_ext;

  logic            in_acc;

  // Result register.
  logic            out_valid_q;
  logic [7:0]      value_byte_q;
  logic            value_valid_q;
  logic [4:0]      record_index_q;
  logic [7:0]      record_type_q;
  logic [15:0]     record_length_q;
  logic            record_done_q;
  logic            message_done_q;
  logic [1:0]      status_out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign crc_step = tlv_pkg::crc_byte(crc_q, data_byte_i);
  assign pos      = len_q - left_q;
  assign left_dec = left_q - 16'd1;

  // Expected checksum byte, most significant first.
  always_comb begin
    case (pos[1:0])
      2'd0:    exp_byte = crc_start_q[31:24];
      2'd1:    exp_byte = crc_start_q[23:16];
      2'd2:    exp_byte = crc_start_q[15:8];
      default: exp_byte = crc_start_q[7:0];
    endcase
  end

  assign byte_miss = (pos[15:2] == 14'd0) && (exp_byte != data_byte_i);

  always_comb begin
    nx_phase     = phase_q;
    nx_count     = count_q;
    nx_type      = type_q;
    nx_len       = len_q;
    nx_left      = left_q;
    nx_crc       = crc_q;
    nx_crc_start = crc_start_q;
    nx_cmpf      = cmpf_q;
    nx_status    = status_q;
    vvalid       = 1'b0;
    rdone        = 1'b0;
    fin          = 1'b0;

    case (phase_q)
      PhType: begin
        if (count_q >= MaxCnt) begin
          // Record limit reached: drop the rest of the message.
          nx_status = tlv_pkg::StTooMany;
          nx_phase  = PhIgnore;
        end else begin
          nx_type      = data_byte_i;
          nx_len       = 16'd0;
          nx_crc_start = crc_q;
          nx_cmpf      = 1'b0;
          if (last_byte_i) begin
            nx_status = tlv_pkg::StParse;
            nx_phase  = PhIgnore;
          end else begin
            nx_phase = PhLenHi;
          end
        end
      end
      PhLenHi: begin
        nx_len = {data_byte_i, 8'h00};
        if (last_byte_i) begin
          nx_status = tlv_pkg::StParse;
          nx_phase  = PhIgnore;
        end else begin
          nx_phase = PhLenLo;
        end
      end
      PhLenLo: begin
        nx_len  = {len_q[15:8], data_byte_i};
        nx_left = nx_len;
        if (nx_len == 16'd0) begin
          // Empty record completes on its header.
          fin = 1'b1;
        end else if (last_byte_i) begin
          nx_status = tlv_pkg::StParse;
          nx_phase  = PhIgnore;
        end else begin
          nx_phase = PhValue;
        end
      end
      PhValue: begin
        vvalid  = 1'b1;
        nx_crc  = crc_step;
        nx_cmpf = cmpf_q | byte_miss;
        nx_left = left_dec;
        if (left_dec == 16'd0) begin
          fin = 1'b1;
        end else if (last_byte_i) begin
          nx_status = tlv_pkg::StParse;
          nx_phase  = PhIgnore;
        end
      end
      default: begin
        nx_phase = PhIgnore;
      end
    endcase

    // Close the record; a checksum record must be long enough and match.
    if (fin) begin
      if ((nx_type == chk_type_q) && ((nx_len < 16'd4) || nx_cmpf)) begin
        nx_status = tlv_pkg::StMismatch;
        nx_phase  = PhIgnore;
      end else begin
        nx_count = count_q + CntW'(1);
        nx_phase = PhType;
        rdone    = 1'b1;
      end
    end
  end

  // Start the next message from a clean state after its last word.
  always_comb begin
    if (last_byte_i) begin
      phase_d     = PhType;
      count_d     = '0;
      type_d      = 8'd0;
      len_d       = 16'd0;
      left_d      = 16'd0;
      crc_d       = 32'd0;
      crc_start_d = 32'd0;
      cmpf_d      = 1'b0;
      status_d    = tlv_pkg::StOk;
    end else begin
      phase_d     = nx_phase;
      count_d     = nx_count;
      type_d      = nx_type;
      len_d       = nx_len;
      left_d      = nx_left;
      crc_d       = nx_crc;
      crc_start_d = nx_crc_start;
      cmpf_d      = nx_cmpf;
      status_d    = nx_status;
    end
  end

  // Record index shows the low five bits of the count.
  assign idx_ext = {5'd0, nx_count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_type_q  <= 8'd0;
      phase_q     <= PhType;
      count_q     <= '0;
      type_q      <= 8'd0;
      len_q       <= 16'd0;
      left_q      <= 16'd0;
      crc_q       <= 32'd0;
      crc_start_q <= 32'd0;
      cmpf_q      <= 1'b0;
      status_q    <= tlv_pkg::StOk;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chk_type_q <= cfg_data_i;
      end
      if (in_acc) begin
        phase_q     <= phase_d;
        count_q     <= count_d;
        type_q      <= type_d;
        len_q       <= len_d;
        left_q      <= left_d;
        crc_q       <= crc_d;
        crc_start_q <= crc_start_d;
        cmpf_q      <= cmpf_d;
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      value_byte_q    <= vvalid ? data_byte_i : 8'd0;
      value_valid_q   <= vvalid;
      record_index_q  <= idx_ext[4:0];
      record_type_q   <= nx_type;
      record_length_q <= nx_len;
      record_done_q   <= rdone;
      message_done_q  <= last_byte_i;
      status_out_q    <= nx_status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign value_byte_o    = value_byte_q;
  assign value_valid_o   = value_valid_q;
  assign record_index_o  = record_index_q;
  assign record_type_o   = record_type_q;
  assign record_length_o = record_length_q;
  assign record_done_o   = record_done_q;
  assign message_done_o  = message_done_q;
  assign status_o        = status_out_q;

  // A completed record is only reported while the message is clean.
  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && record_done_q |-> status_out_q == tlv_pkg::StOk)
    else $error("record done reported with error status");

  // The record count never passes the limit.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("record count above limit");

  // The last word of a message leaves the parser cleared.
  a_msg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> phase_q == PhType && count_q == '0 &&
                              status_q == tlv_pkg::StOk && crc_q == 32'd0)
    else $error("parser not cleared after message end");

  // Once in error, the parser only leaves ignore at the message end.
  a_ignore_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIgnore && in_acc && !last_byte_i |=> phase_q == PhIgnore)
    else $error("parser left ignore phase early");

endmodule

`default_nettype wire

@@ dv/tb_tlv_stream_parser_crc32_core.sv @@
// Self-checking testbench for the TLV stream parser with chained CRC-32 check.
`timescale 1ns / 100ps

module tb_tlv_stream_parser_crc32_core;

  localparam int MaxRecords    = 16;
  localparam int PhaseBytes    = 160;   // random bytes per checksum-type setting
  localparam int NumSettings   = 6;
  localparam int MaxGap        = 12;
  localparam int HoldOffCycles = 90;    // one long receiver stall to back up the input
  localparam int HoldOffAt     = 300;   // result count at which that stall starts
  localparam int StallLimit    = 2000;  // cycles without any word moving
  localparam int ReportLimit   = 10;

  // One result word of the block, field order as on the ports.
  typedef struct packed {
    logic [7:0]  value_byte;
    logic        value_valid;
    logic [4:0]  record_index;
    logic [7:0]  record_type;
    logic [15:0] record_length;
    logic        record_done;
    logic        message_done;
    logic [1:0]  status;
  } parse_result_t;

  // One input word, with an optional hand-written expected result.
  typedef struct {
    logic [7:0]    data;
    logic          last;
    bit            pinned;
    parse_result_t want;
  } word_t;

  typedef enum logic [2:0] {
    ExpectType,
    ExpectLenHi,
    ExpectLenLo,
    InValue,
    Discard
  } parse_phase_e;

  // ---------------------------------------------------------------------------
  // Clock, reset and the signals around the block
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_data  = 8'h00;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_ready = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [7:0]  value_byte;
  logic        value_valid;
  logic [4:0]  record_index;
  logic [7:0]  record_type;
  logic [15:0] record_length;
  logic        record_done;
  logic        message_done;
  logic [1:0]  status;

  parse_result_t got;
  assign got = {value_byte, value_valid, record_index, record_type, record_length,
                record_done, message_done, status};

  always #10 clk = ~clk;

  tlv_stream_parser_crc32_core #(
    .MAX_RECORDS(MaxRecords)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .value_byte_o   (value_byte),
    .value_valid_o  (value_valid),
    .record_index_o (record_index),
    .record_type_o  (record_type),
    .record_length_o(record_length),
    .record_done_o  (record_done),
    .message_done_o (message_done),
    .status_o       (status)
  );

  // ---------------------------------------------------------------------------
  // Parser prediction: own copy of the message state and the checksum type
  // ---------------------------------------------------------------------------
  logic [7:0]   ck_type;
  parse_phase_e ph;
  logic [7:0]   rec_count;     // saturates at 255, shows up masked to 5 bits
  logic [7:0]   cur_type;
  logic [15:0]  cur_len;
  logic [15:0]  left;
  logic [31:0]  crc_run;
  logic [31:0]  crc_start;     // CRC of the records closed before this one
  bit           cmp_bad;
  logic [1:0]   msg_st;

  parse_result_t pending_results[$];

  // Reflected CRC-32, inverted in and out so that calls chain like zlib.
  function automatic logic [31:0] crc32_feed(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = ~crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = {1'b0, r[31:1]} ^ (r[0] ? 32'hEDB88320 : 32'h0);
    end
    return ~r;
  endfunction

  function automatic void clear_message();
    ph        = ExpectType;
    rec_count = '0;
    cur_type  = '0;
    cur_len   = '0;
    left      = '0;
    crc_run   = '0;
    crc_start = '0;
    cmp_bad   = 1'b0;
    msg_st    = tlv_pkg::StOk;
  endfunction

  // Latch the error and drop every byte up to the end of the message.
  function automatic void abort_message(logic [1:0] code);
    msg_st = code;
    ph     = Discard;
  endfunction

  // Close the current record; a checksum record must be long enough and match.
  function automatic bit close_record();
    if (cur_type == ck_type && (cur_len < 16'd4 || cmp_bad)) begin
      abort_message(tlv_pkg::StMismatch);
      return 1'b0;
    end
    if (rec_count < 8'd255) rec_count++;
    ph = ExpectType;
    return 1'b1;
  endfunction

  // Advance the message state by one byte and return the result it produces.
  task automatic parse_byte(input logic [7:0] b, input logic last, output parse_result_t r);
    int          pos;
    logic [31:0] hdr;
    bit          vv;
    bit          done;
    vv   = 1'b0;
    done = 1'b0;
    case (ph)
      ExpectType: begin
        if (rec_count >= MaxRecords) begin
          abort_message(tlv_pkg::StTooMany);
        end else begin
          cur_type  = b;
          cur_len   = '0;
          crc_start = crc_run;
          cmp_bad   = 1'b0;
          if (last) abort_message(tlv_pkg::StParse);
          else ph = ExpectLenHi;
        end
      end
      ExpectLenHi: begin
        cur_len = {b, 8'h00};
        if (last) abort_message(tlv_pkg::StParse);
        else ph = ExpectLenLo;
      end
      ExpectLenLo: begin
        cur_len[7:0] = b;
        left = cur_len;
        // A zero length record closes on its header, even on the last byte.
        if (cur_len == 16'd0) done = close_record();
        else if (last) abort_message(tlv_pkg::StParse);
        else ph = InValue;
      end
      InValue: begin
        pos = cur_len - left;
        vv  = 1'b1;
        crc_run = crc32_feed(crc_run, b);
        // Compare the first four value bytes against the stored CRC, MSB first.
        if (pos < 4) begin
          hdr = crc_start >> (24 - 8 * pos);
          if (hdr[7:0] != b) cmp_bad = 1'b1;
        end
        left = left - 16'd1;
        if (left == 16'd0) done = close_record();
        else if (last) abort_message(tlv_pkg::StParse);
      end
      default: ph = Discard;
    endcase
    r.value_byte    = vv ? b : 8'h00;
    r.value_valid   = vv;
    r.record_index  = rec_count[4:0];
    r.record_type   = cur_type;
    r.record_length = cur_len;
    r.record_done   = done;
    r.message_done  = last;
    r.status        = msg_st;
    if (last) clear_message();
  endtask

  // ---------------------------------------------------------------------------
  // Sender: random gaps per word, calm stretches with back-to-back words
  // ---------------------------------------------------------------------------
  bit tx_calm = 1'b0;
  int bytes_sent = 0;
  int messages_sent = 0;

  task automatic send_word(input word_t w);
    int            gap;
    parse_result_t predicted;
    if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // Hold valid and payload until the block takes the word.
    in_valid  <= 1'b1;
    data_byte <= w.data;
    last_byte <= w.last;
    do begin
      @(posedge clk);
    end while (!in_ready);
    parse_byte(w.data, w.last, predicted);
    pending_results.push_back(w.pinned ? w.want : predicted);
    bytes_sent++;
  endtask

  function automatic word_t plain(logic [7:0] d, logic l);
    word_t w;
    w.data   = d;
    w.last   = l;
    w.pinned = 1'b0;
    w.want   = '0;
    return w;
  endfunction

  function automatic word_t pinned(logic [7:0] d, logic l, logic [7:0] vb, bit vv,
                                   logic [4:0] idx, logic [7:0] t, logic [15:0] len,
                                   bit done, logic [1:0] st);
    word_t w;
    w.data   = d;
    w.last   = l;
    w.pinned = 1'b1;
    w.want   = {vb, vv, idx, t, len, done, l, st};
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Random message builder
  // ---------------------------------------------------------------------------
  word_t msg_q[$];

  // Fill msg_q with one message; useful counts the bytes up to the first error.
  task automatic build_message(output int useful);
    int          kind;
    int          n;
    int          bad_at;
    int          corrupt_pos;
    int          cut;
    bit          ck;
    logic [15:0] len;
    logic [7:0]  t;
    logic [7:0]  b;
    logic [31:0] run;
    logic [31:0] seg_start;
    logic [31:0] sh;
    msg_q.delete();
    useful = -1;
    run    = '0;
    kind   = $urandom_range(0, 9);
    // 0..5 well formed, 6 too many records, 7 cut short, 8 bad checksum, 9 noise
    n      = (kind == 6) ? MaxRecords + $urandom_range(1, 2) : $urandom_range(1, 6);
    bad_at = (kind == 8) ? $urandom_range(0, n - 1) : -1;
    for (int r = 0; r < n; r++) begin
      if (kind == 6 && r == MaxRecords && useful < 0) useful = msg_q.size() + 1;
      ck = (r == bad_at) || ($urandom_range(0, 2) == 0);
      if (ck) begin
        t   = ck_type;
        len = 16'($urandom_range(4, 8));
      end else begin
        t = 8'($urandom_range(0, 255));
        if (t == ck_type) t = ~t;
        if (kind == 6) len = 16'($urandom_range(0, 2));
        else if ($urandom_range(0, 7) == 0) len = 16'($urandom_range(7, 40));
        else len = 16'($urandom_range(0, 6));
      end
      corrupt_pos = -1;
      if (r == bad_at) begin
        if ($urandom_range(0, 1) == 1) len = 16'($urandom_range(0, 3));
        else corrupt_pos = $urandom_range(0, 3);
      end
      msg_q.push_back(plain(t, 1'b0));
      msg_q.push_back(plain(len[15:8], 1'b0));
      msg_q.push_back(plain(len[7:0], 1'b0));
      seg_start = run;
      for (int i = 0; i < len; i++) begin
        if (ck && i < 4) begin
          sh = seg_start >> (24 - 8 * i);
          b  = sh[7:0];
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        if (i == corrupt_pos) b = b ^ (8'h01 << $urandom_range(0, 7));
        msg_q.push_back(plain(b, 1'b0));
        run = crc32_feed(run, b);
      end
      if (r == bad_at) useful = msg_q.size();
    end
    if (kind == 7) begin
      cut = $urandom_range(0, msg_q.size() - 2);
      while (msg_q.size() > cut + 1) void'(msg_q.pop_back());
    end
    if (kind == 9) begin
      msg_q.delete();
      repeat ($urandom_range(1, 10)) msg_q.push_back(plain(8'($urandom_range(0, 255)), 1'b0));
      useful = 1;
    end
    msg_q[msg_q.size() - 1].last = 1'b1;
    if (useful < 0 || useful > msg_q.size()) useful = msg_q.size();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : drain_results
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      // The long hold-off lets the result register fill and stall the input.
      if (taken == HoldOffAt) stall = HoldOffCycles;
      else stall = calm ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!out_valid);
      taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking against the oldest expectation
  // ---------------------------------------------------------------------------
  int failures = 0;
  int results_checked = 0;
  int records_closed = 0;
  int endings[4] = '{0, 0, 0, 0};

  function automatic string describe_result(parse_result_t r);
    return $sformatf("byte=%h vld=%b rec=%0d type=%h len=%h done=%b end=%b st=%0d",
                     r.value_byte, r.value_valid, r.record_index, r.record_type,
                     r.record_length, r.record_done, r.message_done, r.status);
  endfunction

  function automatic bit same_result(parse_result_t a, parse_result_t b);
    return a.value_byte == b.value_byte && a.value_valid == b.value_valid &&
           a.record_index == b.record_index && a.record_type == b.record_type &&
           a.record_length == b.record_length && a.record_done == b.record_done &&
           a.message_done == b.message_done && a.status == b.status;
  endfunction

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= ReportLimit) $display("Unexpected result: %s", describe_result(got));
      end else begin
        want = pending_results.pop_front();
        if (!same_result(want, got)) begin
          failures++;
          if (failures <= ReportLimit) begin
            $display("Mismatch on result %0d", results_checked);
            $display("  expected %s", describe_result(want));
            $display("  actual   %s", describe_result(got));
          end
        end
      end
      results_checked++;
      if (got.record_done) records_closed++;
      if (got.message_done) endings[got.status]++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no word moves for too long
  // ---------------------------------------------------------------------------
  int stall_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < StallLimit) @(posedge clk);
    $display("Watchdog: no word moved for %0d cycles", StallLimit);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: directed messages, then random messages per checksum type
  // ---------------------------------------------------------------------------
  initial begin : run_test
    word_t       rows[$];
    logic [31:0] first_crc;
    logic [7:0]  setting;
    int          useful;
    int          phase_bytes;
    int          cfg_writes;

    ck_type = 8'h00;
    clear_message();
    cfg_writes = 0;

    // Directed rows; checksum type is still at its reset value 0.
    first_crc = crc32_feed(32'h0, 8'hFF);
    // One-byte record, then a checksum record that carries its CRC.
    rows.push_back(pinned(8'h5A, 0, 8'h00, 0, 0, 8'h5A, 16'h0000, 0, tlv_pkg::StOk));
    rows.push_back(pinned(8'h00, 0, 8'h00, 0, 0, 8'h5A, 16'h0000, 0, tlv_pkg::StOk));
    rows.push_back(pinned(8'h01, 0, 8'h00, 0, 0, 8'h5A, 16'h0001, 0, tlv_pkg::StOk));
    rows.push_back(pinned(8'hFF, 0, 8'hFF, 1, 1, 8'h5A, 16'h0001, 1, tlv_pkg::StOk));
    rows.push_back(pinned(8'h00, 0, 8'h00, 0, 1, 8'h00, 16'h0000, 0, tlv_pkg::StOk));
    rows.push_back(pinned(8'h00, 0, 8'h00, 0, 1, 8'h00, 16'h0000, 0, tlv_pkg::StOk));
    rows.push_back(pinned(8'h04, 0, 8'h00, 0, 1, 8'h00, 16'h0004, 0, tlv_pkg::StOk));
    rows.push_back(plain(first_crc[31:24], 0));
    rows.push_back(plain(first_crc[23:16], 0));
    rows.push_back(plain(first_crc[15:8], 0));
    rows.push_back(plain(first_crc[7:0], 1));
    // Message that ends on its type byte.
    rows.push_back(pinned(8'h01, 1, 8'h00, 0, 0, 8'h01, 16'h0000, 0, tlv_pkg::StParse));
    // Zero length record closing on the last byte: complete, not an error.
    rows.push_back(pinned(8'h80, 0, 8'h00, 0, 0, 8'h80, 16'h0000, 0, tlv_pkg::StOk));
    rows.push_back(pinned(8'h00, 0, 8'h00, 0, 0, 8'h80, 16'h0000, 0, tlv_pkg::StOk));
    rows.push_back(pinned(8'h00, 1, 8'h00, 0, 1, 8'h80, 16'h0000, 1, tlv_pkg::StOk));
    // Message that ends inside the length.
    rows.push_back(pinned(8'hFF, 0, 8'h00, 0, 0, 8'hFF, 16'h0000, 0, tlv_pkg::StOk));
    rows.push_back(pinned(8'hFF, 1, 8'h00, 0, 0, 8'hFF, 16'hFF00, 0, tlv_pkg::StParse));
    // Largest length, cut short in the value.
    rows.push_back(plain(8'h7E, 0));
    rows.push_back(plain(8'hFF, 0));
    rows.push_back(plain(8'hFF, 0));
    rows.push_back(pinned(8'h55, 1, 8'h55, 1, 0, 8'h7E, 16'hFFFF, 0, tlv_pkg::StParse));
    // Checksum record shorter than four bytes, then a byte that is dropped.
    rows.push_back(plain(8'h00, 0));
    rows.push_back(plain(8'h00, 0));
    rows.push_back(plain(8'h02, 0));
    rows.push_back(pinned(8'h00, 0, 8'h00, 1, 0, 8'h00, 16'h0002, 0, tlv_pkg::StOk));
    rows.push_back(pinned(8'h00, 0, 8'h00, 1, 0, 8'h00, 16'h0002, 0, tlv_pkg::StMismatch));
    rows.push_back(pinned(8'h33, 1, 8'h00, 0, 0, 8'h00, 16'h0002, 0, tlv_pkg::StMismatch));

    // Hold reset at the start, then release it once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_word(rows[i]);
    messages_sent += 6;

    for (int p = 0; p < NumSettings; p++) begin
      if (p > 0) begin
        // Change the checksum type only with the block drained.
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        if (p == 1) setting = 8'hFF;
        else if (p == 2) setting = 8'h00;
        else setting = 8'($urandom_range(0, 255));
        cfg_we   <= 1'b1;
        cfg_data <= setting;
        @(posedge clk);
        cfg_we  <= 1'b0;
        ck_type  = setting;
        cfg_writes++;
      end
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        build_message(useful);
        phase_bytes += useful;
        messages_sent++;
        foreach (msg_q[i]) send_word(msg_q[i]);
      end
      in_valid <= 1'b0;
    end

    // Wait out the remaining results, then keep watching for stray ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Summary: %0d bytes in %0d messages, %0d results, %0d records closed, %0d %s",
             bytes_sent, messages_sent, results_checked, records_closed, cfg_writes,
             "checksum type writes");
    $display("Message endings: %0d clean, %0d too many records, %0d cut short, %0d bad checksum",
             endings[tlv_pkg::StOk], endings[tlv_pkg::StTooMany],
             endings[tlv_pkg::StParse], endings[tlv_pkg::StMismatch]);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/tlv_pkg.sv
hdl/tlv_stream_parser_crc32_core.sv
dv/tb_tlv_stream_parser_crc32_core.sv
